// ===== src/mmu_pkg.sv =====
// shared types and constants for the matrix multiply unit
// used by mmu_store, mmu_mac and matrix_multiply_unit; no dependencies
package mmu_pkg;

  localparam int unsigned DIM_DEFAULT = 8;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned PROD_W  = 2 * ELEM_W;
  localparam int unsigned SUM_W   = 35;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [MODE_W-1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START       = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_SECOND = 2'd2;

  // travels alongside each store read into the multiply-accumulate pipe
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mmu_tag_t;

endpackage

// ===== src/mmu_store.sv =====
// element store: one write port, one read port, registered read data
// depends on mmu_pkg for the element width
module mmu_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [mmu_pkg::ELEM_W-1:0]  wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [mmu_pkg::ELEM_W-1:0]  rdata_o
);
  import mmu_pkg::*;

  logic [ELEM_W-1:0] mem_q [DEPTH];
  logic [ELEM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mmu_mac.sv =====
// multiply-accumulate pipe: registered 16x16 product, then a 35-bit accumulator
// depends on mmu_pkg for widths and the tag struct
module mmu_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mmu_pkg::mmu_tag_t                  tag_i,
  input  logic signed [mmu_pkg::ELEM_W-1:0]  a_i,
  input  logic signed [mmu_pkg::ELEM_W-1:0]  b_i,
  output logic signed [mmu_pkg::SUM_W-1:0]   acc_o,
  output logic                               done_o
);
  import mmu_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  mmu_tag_t                 tag_q;
  logic signed [SUM_W-1:0]  acc_q;
  logic                     done_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= '0;
      done_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      tag_q  <= tag_i;
      done_q <= tag_q.valid && tag_q.last;
      if (tag_q.valid) begin
        // first term of a dot product restarts the sum
        acc_q <= tag_q.first ? SUM_W'(prod_q) : acc_q + SUM_W'(prod_q);
      end
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

// ===== src/matrix_multiply_unit.sv =====
// matrix multiply unit: loads A and B elements, then streams P = A * B row-major
// a start issues one A and one B read per inner term on the single read port of
// each store; the products pass the read, multiply and accumulate stages, and
// the word is pushed once the sum is done; each further word repeats this, so
// a new word is not begun before the last one is pushed; with inner_size 0 the
// words are zero and go out one per cycle while the consumer takes them
// loads one per cycle while idle; reset clears control and sizes (DIM), not stores
module matrix_multiply_unit #(
  parameter int unsigned DIM = mmu_pkg::DIM_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // mode[1:0], elem_row[4:2], elem_col[7:5], element_value[23:8]
  input  logic [mmu_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_row[2:0], out_col[5:3], product_value[40:6], zero fill above
  output logic [mmu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,
  input  logic                                cfg_we_i,
  input  logic [mmu_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mmu_pkg::CFG_W-1:0]           cfg_data_i
);
  import mmu_pkg::*;

  localparam int unsigned IW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned CW    = $clog2(DIM + 1);
  localparam int unsigned DEPTH = DIM * DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_PUSH
  } state_e;

  function automatic logic [CW-1:0] clamp_size(input logic [CFG_W-1:0] v);
    if (int'(v) > DIM) begin
      return CW'(DIM);
    end
    return CW'(v);
  endfunction

  // configuration, kept already clamped to DIM
  logic [CW-1:0] rows_q, inner_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= CW'(DIM);
      inner_q <= CW'(DIM);
      cols_q  <= CW'(DIM);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS_FIRST:  rows_q  <= clamp_size(cfg_data_i);
        CFG_INNER_SIZE:  inner_q <= clamp_size(cfg_data_i);
        CFG_COLS_SECOND: cols_q  <= clamp_size(cfg_data_i);
        default: ;
      endcase
    end
  end

  // input word
  logic [MODE_W-1:0] in_mode;
  logic [IDX_W-1:0]  in_row, in_col;
  logic [ELEM_W-1:0] in_value;
  logic              in_acc, in_range;

  assign in_mode  = s_axis_tdata[1:0];
  assign in_row   = s_axis_tdata[4:2];
  assign in_col   = s_axis_tdata[7:5];
  assign in_value = s_axis_tdata[23:8];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_range = ({1'b0, in_row} < 4'(DIM)) && ({1'b0, in_col} < 4'(DIM));

  // sequencer
  state_e            state_q;
  logic [IW-1:0]     i_q, j_q, k_q;
  logic [CW-1:0]     nr_q, nk_q, nc_q;
  mmu_tag_t          tag_d, tag_q;
  logic              out_valid_q, out_last_q;
  logic [IDX_W-1:0]  out_row_q, out_col_q;
  logic signed [SUM_W-1:0] out_val_q;

  logic i_last, j_last, k_last, out_free, out_load, out_last_d;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic signed [ELEM_W-1:0] rdata_a, rdata_b;
  logic signed [SUM_W-1:0]  mac_acc;
  logic mac_done;

  assign i_last = (CW'(i_q) + CW'(1)) == nr_q;
  assign j_last = (CW'(j_q) + CW'(1)) == nc_q;
  assign k_last = (CW'(k_q) + CW'(1)) == nk_q;
  assign out_free   = !out_valid_q || m_axis_tready;
  assign out_load   = (state_q == ST_PUSH) && out_free;
  assign out_last_d = i_last && j_last;

  assign tag_d.valid = (state_q == ST_ISSUE);
  assign tag_d.first = (k_q == '0);
  assign tag_d.last  = k_last;

  assign waddr   = AW'(in_row) * AW'(DIM) + AW'(in_col);
  assign raddr_a = AW'(i_q) * AW'(DIM) + AW'(k_q);
  assign raddr_b = AW'(k_q) * AW'(DIM) + AW'(j_q);

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      nr_q        <= '0;
      nk_q        <= '0;
      nc_q        <= '0;
      tag_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_val_q   <= '0;
    end else begin
      tag_q <= tag_d;
      case (state_q)
        ST_IDLE: begin
          if (in_acc && in_mode == MODE_START) begin
            nr_q <= rows_q;
            nk_q <= inner_q;
            nc_q <= cols_q;
            i_q  <= '0;
            j_q  <= '0;
            k_q  <= '0;
            if (rows_q != '0 && cols_q != '0) begin
              state_q <= (inner_q == '0) ? ST_PUSH : ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          if (k_last) begin
            k_q     <= '0;
            state_q <= ST_WAIT;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            if (out_last_d) begin
              state_q <= ST_IDLE;
            end else begin
              if (j_last) begin
                j_q <= '0;
                i_q <= i_q + 1'b1;
              end else begin
                j_q <= j_q + 1'b1;
              end
              state_q <= (nk_q == '0) ? ST_PUSH : ST_ISSUE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // output word register parts the sequencer from the consumer
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_row_q   <= IDX_W'(i_q);
        out_col_q   <= IDX_W'(j_q);
        out_val_q   <= (nk_q == '0) ? '0 : mac_acc;
        out_last_q  <= out_last_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  mmu_store #(.DEPTH(DEPTH), .AW(AW)) u_first_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && in_mode == MODE_LOAD_FIRST && in_range),
    .waddr_i (waddr),
    .wdata_i (in_value),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mmu_store #(.DEPTH(DEPTH), .AW(AW)) u_second_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && in_mode == MODE_LOAD_SECOND && in_range),
    .waddr_i (waddr),
    .wdata_i (in_value),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  mmu_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag_q),
    .a_i    (rdata_a),
    .b_i    (rdata_b),
    .acc_o  (mac_acc),
    .done_o (mac_done)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - SUM_W - 2 * IDX_W){1'b0}},
                          out_val_q, out_col_q, out_row_q};

  // no store reads in flight while new words are taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !tag_q.valid)
    else $error("store read in flight while idle");

  // a finished dot product only shows up while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> state_q == ST_WAIT)
    else $error("accumulator done outside wait state");

  // a pending output word is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && m_axis_tvalid) |-> m_axis_tready)
    else $error("output word overwritten");

  // the marked word ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> state_q == ST_IDLE)
    else $error("run continues after last word");

endmodule
